[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define VROP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VROP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define VROP_ASSERT(lbl, clk, rst_n, prop, msg)
`define VROP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

[rtl/vrop_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrop_pkg
// Shared types and constants of the 2bpp vertical raster-op engine.
// ----------------------------------------------------------------------------
package vrop_pkg;

    localparam int QUEUE_DEPTH = 2;

    // Low two bits of draw_mode; bit 2 inverts the source bits.
    localparam logic [1:0] MODE_FLIP  = 2'd0;
    localparam logic [1:0] MODE_BG    = 2'd1;
    localparam logic [1:0] MODE_FG    = 2'd2;
    localparam logic [1:0] MODE_SOLID = 2'd3;

    typedef enum logic [2:0] {
        K_LOAD_DISP,
        K_LOAD_BACK,
        K_READ,
        K_ROP,
        K_REJECT
    } t_kind;

    // One classified command between front and back.
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  row;        // first word row
        logic [6:0]  column;
        logic [15:0] data;       // load data or source bits
        logic [15:0] mask;       // mask of the first word
        logic [7:0]  last_byte;  // per-plane mask of the last word
        logic [3:0]  extra;      // word rows after the first
    } t_cmd;

    typedef struct packed {
        logic [1:0] fg_level;
        logic [1:0] bg_level;
        logic [2:0] draw_mode;
        logic       backdrop_on;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic pop;
    } t_back_stat;

    function automatic logic [15:0] grey_pattern(input logic [1:0] level);
        logic [15:0] pat;
        case (level)
            2'd0:    pat = 16'hFFFF;
            2'd1:    pat = 16'hFF00;
            2'd2:    pat = 16'h00FF;
            default: pat = 16'h0000;
        endcase
        return pat;
    endfunction

endpackage

[rtl/vrop_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrop_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module vrop_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/vrop_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrop_front
// Accepts input transactions, range-checks them and turns them into commands.
// ----------------------------------------------------------------------------
module vrop_front import vrop_pkg::*; #(
    parameter int FB_WIDTH = 128,
    parameter int FB_ROWS  = 16
) (
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [6:0]  i_column,
    input  logic [3:0]  i_word_row,
    input  logic [15:0] i_word_data,
    input  logic [15:0] i_pixel_mask,
    input  logic [15:0] i_pixel_bits,
    input  logic [6:0]  i_y_first,
    input  logic [6:0]  i_y_last,
    input  logic        i_queue_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    typedef enum logic [2:0] {
        ACT_LOAD_DISP = 3'd0,
        ACT_LOAD_BACK = 3'd1,
        ACT_READ_DISP = 3'd2,
        ACT_BLOCK_OP  = 3'd3,
        ACT_SPAN_FILL = 3'd4
    } t_action;

    logic       col_bad;
    logic       row_bad;
    logic       span_bad;
    logic [6:0] span_len;
    logic [7:0] top_byte;
    logic [7:0] bot_byte;
    t_cmd       cmd;

    always_comb begin
        col_bad  = 32'(i_column) >= 32'(FB_WIDTH);
        row_bad  = 32'(i_word_row) >= 32'(FB_ROWS);
        span_bad = (i_y_first > i_y_last) || (32'(i_y_last) >= 32'(FB_ROWS * 8));
        // span length counted from the top of the first word row
        span_len = i_y_last - {i_y_first[6:3], 3'b000};
        top_byte = 8'hFF << i_y_first[2:0];
        bot_byte = 8'hFF >> (3'd7 - span_len[2:0]);

        cmd           = '0;
        cmd.kind      = K_REJECT;
        cmd.row       = i_word_row;
        cmd.column    = i_column;
        cmd.data      = i_word_data;
        cmd.mask      = i_pixel_mask;
        cmd.last_byte = 8'hFF;
        cmd.extra     = 4'd0;

        case (i_action)
            ACT_LOAD_DISP: begin
                cmd.kind = (col_bad || row_bad) ? K_REJECT : K_LOAD_DISP;
            end
            ACT_LOAD_BACK: begin
                cmd.kind = (col_bad || row_bad) ? K_REJECT : K_LOAD_BACK;
            end
            ACT_READ_DISP: begin
                cmd.kind = (col_bad || row_bad) ? K_REJECT : K_READ;
            end
            ACT_BLOCK_OP: begin
                cmd.kind = (col_bad || row_bad) ? K_REJECT : K_ROP;
                cmd.data = i_pixel_bits;
            end
            ACT_SPAN_FILL: begin
                cmd.kind      = (col_bad || span_bad) ? K_REJECT : K_ROP;
                cmd.row       = i_y_first[6:3];
                cmd.data      = 16'hFFFF;
                cmd.mask      = {top_byte, top_byte};
                cmd.last_byte = bot_byte;
                cmd.extra     = span_len[6:3];
            end
            default: begin
                cmd.kind = K_REJECT;
            end
        endcase
    end

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;
    assign o_cmd      = cmd;

endmodule

[rtl/vrop_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrop_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module vrop_queue import vrop_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));

endmodule

[rtl/vrop_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrop_back
// Executes commands on the display and backdrop memories and holds the result.
// ----------------------------------------------------------------------------
module vrop_back import vrop_pkg::*; #(
    parameter int FB_WIDTH = 128,
    parameter int FB_ROWS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_queue_empty,
    input  t_cmd        i_head,
    output t_back_stat  o_stat,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [15:0] o_read_word,
    output logic        o_status
);

    localparam int DEPTH  = FB_WIDTH * FB_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_MODIFY
    } t_state;

    t_state      r_state;
    t_cmd        r_cmd;
    logic        r_first;
    logic        r_out_valid;
    logic [15:0] r_read_word;
    logic        r_status;

    logic              out_free;
    logic              pop;
    logic              last_word;
    logic              n_out_valid;
    logic [15:0]       word_mask;
    logic [15:0]       bg_pat;
    logic [15:0]       new_word;
    logic [15:0]       disp_rd;
    logic [15:0]       back_rd;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       disp_wr_data;
    logic              disp_we;
    logic              back_we;

    function automatic logic [ADDR_W-1:0] word_addr(input logic [4:0] row,
                                                    input logic [6:0] col);
        return ADDR_W'(32'(row) * 32'(FB_WIDTH) + 32'(col));
    endfunction

    function automatic logic [15:0] rop_word(input logic [15:0] d,
                                             input logic [15:0] fgp,
                                             input logic [15:0] bgp,
                                             input logic [15:0] bits,
                                             input logic [15:0] mask,
                                             input logic [2:0]  mode);
        logic [15:0] b;
        logic [15:0] src;
        logic [15:0] res;
        b   = mode[2] ? ~bits : bits;
        src = bgp ^ ((bgp ^ fgp) & b);
        case (mode[1:0])
            MODE_FLIP: res = d ^ (b & mask);
            MODE_BG:   res = d ^ ((d ^ bgp) & mask & ~b);
            MODE_FG:   res = d ^ ((d ^ fgp) & mask & b);
            default:   res = d ^ ((d ^ src) & mask);
        endcase
        return res;
    endfunction

    always_comb begin
        out_free  = !r_out_valid || !i_out_stall;
        pop       = (r_state == S_IDLE) && !i_queue_empty && out_free;
        last_word = (r_cmd.extra == 4'd0);

        // Hold a stalled result; load a new one when a command finishes.
        n_out_valid = r_out_valid && i_out_stall;
        if (pop && !(i_head.kind inside {K_READ, K_ROP})) begin
            n_out_valid = 1'b1;
        end
        if ((r_state == S_MODIFY) && last_word) begin
            n_out_valid = 1'b1;
        end

        word_mask = (r_first ? r_cmd.mask : 16'hFFFF) &
                    (last_word ? {r_cmd.last_byte, r_cmd.last_byte} : 16'hFFFF);
        bg_pat    = i_cfg.backdrop_on ? back_rd : grey_pattern(i_cfg.bg_level);
        new_word  = rop_word(disp_rd, grey_pattern(i_cfg.fg_level), bg_pat,
                             r_cmd.data, word_mask, i_cfg.draw_mode);

        // Idle reads the head's word; a span reads its next row while writing this one.
        if (r_state == S_IDLE) begin
            rd_addr = word_addr({1'b0, i_head.row}, i_head.column);
        end else begin
            rd_addr = word_addr({1'b0, r_cmd.row} + 5'd1, r_cmd.column);
        end

        wr_addr      = word_addr({1'b0, i_head.row}, i_head.column);
        disp_wr_data = i_head.data;
        disp_we      = pop && (i_head.kind == K_LOAD_DISP);
        back_we      = pop && (i_head.kind == K_LOAD_BACK);
        if ((r_state == S_MODIFY) && (r_cmd.kind == K_ROP)) begin
            disp_we      = 1'b1;
            wr_addr      = word_addr({1'b0, r_cmd.row}, r_cmd.column);
            disp_wr_data = new_word;
        end
    end

    vrop_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_disp_ram (
        .i_clk     (i_clk),
        .i_wr_en   (disp_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (disp_wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (disp_rd)
    );

    vrop_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_back_ram (
        .i_clk     (i_clk),
        .i_wr_en   (back_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_head.data),
        .i_rd_addr (rd_addr),
        .o_rd_data (back_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_cmd   <= i_head;
                        r_first <= 1'b1;
                        case (i_head.kind)
                            K_READ, K_ROP: begin
                                r_state <= S_MODIFY;
                            end
                            K_REJECT: begin
                                r_read_word <= '0;
                                r_status    <= 1'b1;
                            end
                            default: begin
                                r_read_word <= '0;
                                r_status    <= 1'b0;
                            end
                        endcase
                    end
                end
                S_MODIFY: begin
                    if (last_word) begin
                        r_read_word <= (r_cmd.kind == K_READ) ? disp_rd : 16'h0000;
                        r_status    <= 1'b0;
                        r_state     <= S_IDLE;
                    end else begin
                        // advance to the next word row of the span
                        r_cmd.row   <= r_cmd.row + 4'd1;
                        r_cmd.extra <= r_cmd.extra - 4'd1;
                        r_first     <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy = (r_state == S_MODIFY);
    assign o_stat.pop  = pop;
    assign o_out_valid = r_out_valid;
    assign o_read_word = r_read_word;
    assign o_status    = r_status;

endmodule

[rtl/vertical_2bpp_raster_op_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertical_2bpp_raster_op_engine_top
// Raster-op engine over a 2bpp vertically packed display and backdrop memory.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with one field port each; a
// transaction moves when valid is high and stall is low. Every transaction
// gives exactly one result on o_out_valid / i_out_stall: o_read_word (display
// word for a read, zero otherwise) and o_status (1 = rejected, nothing changed).
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// write only while the engine is idle. o_cfg_ready is always high.
// A command passes the queue and then the output register; a read or block
// op also passes the modify step, which a span fill repeats per word row.
// Loads and rejects are taken one per cycle while the output does not stall;
// a read, block op or span fill holds the execution side until its modify
// steps end, as the display RAM's registered read precedes its single write port.
// A two-entry command queue keeps taking input while the execution side is busy.
// While the receiver stalls, the result is held and no new command starts,
// so input stalls once the queue fills. Reset (synchronous, active low) empties
// the queue and output and restores the registers; memory contents are kept.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertical_2bpp_raster_op_engine_top import vrop_pkg::*; #(
    parameter int FB_WIDTH = 128,
    parameter int FB_ROWS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [6:0]  i_column,
    input  logic [3:0]  i_word_row,
    input  logic [15:0] i_word_data,
    input  logic [15:0] i_pixel_mask,
    input  logic [15:0] i_pixel_bits,
    input  logic [6:0]  i_y_first,
    input  logic [6:0]  i_y_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_read_word,
    output logic        o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_data
);

    typedef enum logic [1:0] {
        CFG_FG_LEVEL    = 2'd0,
        CFG_BG_LEVEL    = 2'd1,
        CFG_DRAW_MODE   = 2'd2,
        CFG_BACKDROP_ON = 2'd3
    } t_cfg_reg;

    t_cfg       r_cfg;
    logic       q_push;
    logic       q_empty;
    logic       q_full;
    t_cmd       q_in;
    t_cmd       q_head;
    t_back_stat back_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fg_level    <= 2'd3;
            r_cfg.bg_level    <= 2'd0;
            r_cfg.draw_mode   <= {1'b0, MODE_SOLID};
            r_cfg.backdrop_on <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FG_LEVEL:    r_cfg.fg_level    <= i_cfg_data[1:0];
                CFG_BG_LEVEL:    r_cfg.bg_level    <= i_cfg_data[1:0];
                CFG_DRAW_MODE:   r_cfg.draw_mode   <= i_cfg_data;
                CFG_BACKDROP_ON: r_cfg.backdrop_on <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    vrop_front #(
        .FB_WIDTH (FB_WIDTH),
        .FB_ROWS  (FB_ROWS)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_column     (i_column),
        .i_word_row   (i_word_row),
        .i_word_data  (i_word_data),
        .i_pixel_mask (i_pixel_mask),
        .i_pixel_bits (i_pixel_bits),
        .i_y_first    (i_y_first),
        .i_y_last     (i_y_last),
        .i_queue_full (q_full),
        .o_push       (q_push),
        .o_cmd        (q_in)
    );

    vrop_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (back_stat.pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    vrop_back #(
        .FB_WIDTH (FB_WIDTH),
        .FB_ROWS  (FB_ROWS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_queue_empty (q_empty),
        .i_head        (q_head),
        .o_stat        (back_stat),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_read_word   (o_read_word),
        .o_status      (o_status)
    );

    // A command starts only when its result will have room in the output register.
    `VROP_ASSERT(a_pop_room, i_clk, i_rst_n, back_stat.pop |-> (!o_out_valid || !i_out_stall), "command started with output register blocked")
    // Memory commands must move the back side into its modify step.
    `VROP_ASSERT(a_mem_busy, i_clk, i_rst_n, back_stat.pop && (q_head.kind == K_READ || q_head.kind == K_ROP) |=> back_stat.busy, "memory command did not enter modify step")
    // No second command is taken while one is in progress.
    `VROP_ASSERT_NEVER(a_busy_pop, i_clk, i_rst_n, back_stat.busy && back_stat.pop, "queue popped while back side busy")

endmodule
